[rtl/sgm_pkg.sv]
// Shared types, constants and register codes for the Sobel gradient magnitude unit.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package sgm_pkg;

   // Default sizes of the line stores and of the frame
   localparam int MAX_LINE_WIDTH_DEF   = 512;
   localparam int MAX_FRAME_HEIGHT_DEF = 4096;

   // Configuration register widths, reset values and indexes
   localparam int LINE_WIDTH_W       = 10;
   localparam int FRAME_HEIGHT_W     = 13;
   localparam int CSR_DATA_W         = 13;
   localparam int CSR_INDEX_W        = 1;
   localparam int LINE_WIDTH_RESET   = 512;
   localparam int FRAME_HEIGHT_RESET = 512;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Payload widths
   localparam int PIXEL_W      = 8;
   localparam int CENTER_ROW_W = 12;
   localparam int CENTER_COL_W = 9;
   localparam int GRAD_W       = 12;
   localparam int SQUARE_W     = 20;
   localparam int RADICAND_W   = 16;
   localparam int ROOT_W       = 8;

   // Number of square-root cells, one per root bit
   localparam int SQRT_BITS = ROOT_W;

   // Result queue depth; covers every word in flight plus slack
   localparam int RSP_FIFO_DEPTH = 16;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               frame_start;
   } sgm_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]      edge_magnitude;
      logic [CENTER_ROW_W-1:0] center_row;
      logic [CENTER_COL_W-1:0] center_col;
      logic                    frame_last;
   } sgm_rsp_type;

   // Position tag carried alongside a word through the pipeline
   typedef struct packed {
      logic [CENTER_ROW_W-1:0] center_row;
      logic [CENTER_COL_W-1:0] center_col;
      logic                    frame_last;
   } sgm_meta_type;

   // Word handed from one square-root cell to the next
   typedef struct packed {
      logic [RADICAND_W-1:0] radicand;
      logic [ROOT_W-1:0]     root;
      logic                  sat;
      sgm_meta_type          meta;
   } sgm_root_type;

endpackage

[rtl/sgm_line_buffer.sv]
// Pair of line stores (upper and middle rows) with one write and one registered read port.
// Depends on sgm_pkg for the pixel width.
`timescale 1ns / 1ps

module sgm_line_buffer
   import sgm_pkg::*;
#(
   parameter int DEPTH  = MAX_LINE_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [PIXEL_W-1:0] wr_upper,
   input  logic [PIXEL_W-1:0] wr_mid,
   output logic [PIXEL_W-1:0] rd_upper,
   output logic [PIXEL_W-1:0] rd_mid
);

   logic [PIXEL_W-1:0] upper_mem [DEPTH];
   logic [PIXEL_W-1:0] mid_mem   [DEPTH];
   logic [PIXEL_W-1:0] rd_upper_ff;
   logic [PIXEL_W-1:0] rd_mid_ff;

   // Write both rows of one column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_upper;
         mid_mem[wr_addr]   <= wr_mid;
      end
   end

   // Read both rows of one column, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff <= upper_mem[rd_addr];
         rd_mid_ff   <= mid_mem[rd_addr];
      end
   end

   assign rd_upper = rd_upper_ff;
   assign rd_mid   = rd_mid_ff;

endmodule

[rtl/sgm_sqrt_cell.sv]
// One cell of the square-root chain: decides a single root bit and passes the word on.
// Depends on sgm_pkg for sgm_root_type.
`timescale 1ns / 1ps

module sgm_sqrt_cell
   import sgm_pkg::*;
#(
   parameter int BIT_IDX = ROOT_W - 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sgm_root_type in_data,
   output logic         out_valid,
   output sgm_root_type out_data
);

   localparam logic [ROOT_W-1:0] BIT_MASK = ROOT_W'(1) << BIT_IDX;

   logic [ROOT_W-1:0]     trial;
   logic [RADICAND_W-1:0] trial_sq;
   sgm_root_type          data_in;
   logic                  valid_ff;
   sgm_root_type          data_ff;

   // Keep the trial bit when its square still fits under the radicand
   always_comb begin
      trial    = in_data.root | BIT_MASK;
      trial_sq = RADICAND_W'(trial) * RADICAND_W'(trial);
      data_in  = in_data;
      if (!in_data.sat && (trial_sq <= in_data.radicand)) begin
         data_in.root = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/sgm_result_fifo.sv]
// Result queue between the pipeline and the rsp channel.
// Depends on sgm_pkg for sgm_rsp_type.
`timescale 1ns / 1ps

module sgm_result_fifo
   import sgm_pkg::*;
#(
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  sgm_rsp_type push_data,
   output logic        out_valid,
   input  logic        out_stall,
   output sgm_rsp_type out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sgm_rsp_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   tail_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign out_data  = entry_ff[head_ff];

   // Store a word at the tail
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push_valid) begin
            tail_ff <= (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push_valid) - CNT_W'(pop);
      end
   end

endmodule

[rtl/sobel_gradient_magnitude_unit.sv]
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
// Depends on sgm_pkg, sgm_line_buffer, sgm_sqrt_cell and sgm_result_fifo.
`timescale 1ns / 1ps
//
//   port group | dir | handshake          | word
//   -----------+-----+--------------------+--------------------------------------------
//   req_       | in  | req_valid/req_stall| pixel_value, frame_start
//   rsp_       | out | rsp_valid/rsp_stall| edge_magnitude, center_row, center_col,
//              |     |                    | frame_last
//   csr_       | in  | csr_wr_en          | csr_index selects line_width/frame_height
//
// One pixel per clock sustained while req_stall is low. An interior pixel's result passes
// through registers for the line store read, window, gradient, squares and sum, then a chain of
// 8 root cells, one bit per cell, before it reaches the queue.
// After reset the line stores are swept to zero over all MAX_LINE_WIDTH columns; req_stall
// stays high during that pass. req_stall also rises when the 16-entry result queue has
// no slot left for a result still in flight, i.e. only while rsp_stall holds results back.

module sobel_gradient_magnitude_unit
   import sgm_pkg::*;
#(
   parameter int MAX_LINE_WIDTH   = MAX_LINE_WIDTH_DEF,
   parameter int MAX_FRAME_HEIGHT = MAX_FRAME_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sgm_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sgm_rsp_type            rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int ROW_W = $clog2(MAX_FRAME_HEIGHT);
   localparam int OCC_W = $clog2(RSP_FIFO_DEPTH + 1);

   // Clamp a size register into 3..hi
   function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
      logic [31:0] r;
      if (v < 32'd3) begin
         r = 32'd3;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [LINE_WIDTH_W-1:0]   line_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_W'(LINE_WIDTH_RESET);
         frame_height_ff <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wr_data[LINE_WIDTH_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wr_data[FRAME_HEIGHT_W-1:0];
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- clearing pass
   logic             clearing_ff;
   logic [COL_W-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clear_addr_ff == COL_W'(MAX_LINE_WIDTH - 1)) begin
            clearing_ff <= 1'b0;
         end else begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- admission
   logic [OCC_W-1:0] occ_ff;
   logic             req_acc;
   logic             rsp_pop;
   logic             has_res;

   assign req_stall = clearing_ff || (occ_ff == OCC_W'(RSP_FIFO_DEPTH));
   assign req_acc   = req_valid && !req_stall;
   assign rsp_pop   = rsp_valid && !rsp_stall;

   // Reserve a queue slot for every word that will give a result
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + OCC_W'(req_acc && has_res) - OCC_W'(rsp_pop);
      end
   end

   // ---------------------------------------------------------------- position
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;
   logic [31:0]      w_eff;
   logic [31:0]      h_eff;
   logic [31:0]      c_a;
   logic [31:0]      r_a;
   logic [31:0]      c_b;
   logic [31:0]      r_b;
   logic [31:0]      r_c;
   logic [COL_W-1:0] cur_col;
   sgm_meta_type     cur_meta;

   // Wrap the position, tag the window center, pick the next position
   always_comb begin
      w_eff = clamp_size(32'(line_width_ff), 32'(MAX_LINE_WIDTH));
      h_eff = clamp_size(32'(frame_height_ff), 32'(MAX_FRAME_HEIGHT));
      c_a   = req_data.frame_start ? 32'd0 : 32'(col_ff);
      r_a   = req_data.frame_start ? 32'd0 : 32'(row_ff);
      if (c_a >= w_eff) begin
         c_b = 32'd0;
         r_b = r_a + 32'd1;
      end else begin
         c_b = c_a;
         r_b = r_a;
      end
      r_c     = (r_b >= h_eff) ? 32'd0 : r_b;
      cur_col = COL_W'(c_b);
      has_res = (r_c >= 32'd2) && (c_b >= 32'd2);

      cur_meta.center_row = CENTER_ROW_W'(r_c - 32'd1);
      cur_meta.center_col = CENTER_COL_W'(c_b - 32'd1);
      cur_meta.frame_last = (r_c == h_eff - 32'd1) && (c_b == w_eff - 32'd1);

      if (c_b + 32'd1 >= w_eff) begin
         col_in = '0;
         row_in = (r_c + 32'd1 >= h_eff) ? '0 : ROW_W'(r_c + 32'd1);
      end else begin
         col_in = COL_W'(c_b + 32'd1);
         row_in = ROW_W'(r_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line stores
   logic               s1_valid_ff;
   logic               s1_res_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   sgm_meta_type       s1_meta_ff;
   logic               s1_fwd_ff;
   logic [PIXEL_W-1:0] fwd_upper_ff;
   logic [PIXEL_W-1:0] fwd_mid_ff;
   logic [PIXEL_W-1:0] rd_upper;
   logic [PIXEL_W-1:0] rd_mid;
   logic [PIXEL_W-1:0] upper_eff;
   logic [PIXEL_W-1:0] mid_eff;
   logic               lb_wr_en;
   logic [COL_W-1:0]   lb_wr_addr;
   logic [PIXEL_W-1:0] lb_wr_upper;
   logic [PIXEL_W-1:0] lb_wr_mid;

   // Take the previous word's write when it hit the same column
   assign upper_eff = s1_fwd_ff ? fwd_upper_ff : rd_upper;
   assign mid_eff   = s1_fwd_ff ? fwd_mid_ff : rd_mid;

   // Write back the shifted column, or zero during the clearing pass
   assign lb_wr_en    = clearing_ff || s1_valid_ff;
   assign lb_wr_addr  = clearing_ff ? clear_addr_ff : s1_addr_ff;
   assign lb_wr_upper = clearing_ff ? '0 : mid_eff;
   assign lb_wr_mid   = clearing_ff ? '0 : s1_pixel_ff;

   sgm_line_buffer #(
      .DEPTH  (MAX_LINE_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buffer (
      .clock    (clock),
      .rd_en    (req_acc),
      .rd_addr  (cur_col),
      .wr_en    (lb_wr_en),
      .wr_addr  (lb_wr_addr),
      .wr_upper (lb_wr_upper),
      .wr_mid   (lb_wr_mid),
      .rd_upper (rd_upper),
      .rd_mid   (rd_mid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_res_ff    <= has_res;
         s1_addr_ff   <= cur_col;
         s1_pixel_ff  <= req_data.pixel_value;
         s1_meta_ff   <= cur_meta;
         s1_fwd_ff    <= s1_valid_ff && (s1_addr_ff == cur_col);
         fwd_upper_ff <= mid_eff;
         fwd_mid_ff   <= s1_pixel_ff;
      end
   end

   // ---------------------------------------------------------------- window
   logic [2:0][2:0][PIXEL_W-1:0] win_ff;
   logic                         s2_valid_ff;
   sgm_meta_type                 s2_meta_ff;

   // Shift the window left and load the new column
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= upper_eff;
         win_ff[1][2] <= mid_eff;
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_res_ff;
      end
      s2_meta_ff <= s1_meta_ff;
   end

   // ---------------------------------------------------------------- gradients
   logic signed [GRAD_W-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
   logic signed [GRAD_W-1:0] gx_in;
   logic signed [GRAD_W-1:0] gy_in;
   logic signed [GRAD_W-1:0] gx_ff;
   logic signed [GRAD_W-1:0] gy_ff;
   logic                     s3_valid_ff;
   sgm_meta_type             s3_meta_ff;

   always_comb begin
      p00   = $signed(GRAD_W'(win_ff[0][0]));
      p01   = $signed(GRAD_W'(win_ff[0][1]));
      p02   = $signed(GRAD_W'(win_ff[0][2]));
      p10   = $signed(GRAD_W'(win_ff[1][0]));
      p12   = $signed(GRAD_W'(win_ff[1][2]));
      p20   = $signed(GRAD_W'(win_ff[2][0]));
      p21   = $signed(GRAD_W'(win_ff[2][1]));
      p22   = $signed(GRAD_W'(win_ff[2][2]));
      gx_in = (p02 + (p12 <<< 1) + p22) - (p00 + (p10 <<< 1) + p20);
      gy_in = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      s3_meta_ff <= s2_meta_ff;
   end

   // ---------------------------------------------------------------- squares
   logic signed [2*GRAD_W-1:0] sqx_full;
   logic signed [2*GRAD_W-1:0] sqy_full;
   logic [SQUARE_W-1:0]        sqx_ff;
   logic [SQUARE_W-1:0]        sqy_ff;
   logic                       s4_valid_ff;
   sgm_meta_type               s4_meta_ff;

   assign sqx_full = (2*GRAD_W)'(gx_ff) * (2*GRAD_W)'(gx_ff);
   assign sqy_full = (2*GRAD_W)'(gy_ff) * (2*GRAD_W)'(gy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      sqx_ff     <= sqx_full[SQUARE_W-1:0];
      sqy_ff     <= sqy_full[SQUARE_W-1:0];
      s4_meta_ff <= s3_meta_ff;
   end

   // ---------------------------------------------------------------- sum and saturate
   logic [SQUARE_W:0]     sum_sq;
   sgm_root_type          root_in;
   logic [SQRT_BITS:0]    cell_valid;
   sgm_root_type          cell_data [SQRT_BITS+1];
   logic                  s5_valid_ff;
   sgm_root_type          s5_data_ff;

   always_comb begin
      sum_sq           = (SQUARE_W+1)'(sqx_ff) + (SQUARE_W+1)'(sqy_ff);
      root_in.radicand = sum_sq[RADICAND_W-1:0];
      root_in.sat      = |sum_sq[SQUARE_W:RADICAND_W];
      root_in.root     = root_in.sat ? '1 : '0;
      root_in.meta     = s4_meta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_data_ff <= root_in;
   end

   // ---------------------------------------------------------------- root cells
   assign cell_valid[0] = s5_valid_ff;
   assign cell_data[0]  = s5_data_ff;

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_cell
      sgm_sqrt_cell #(
         .BIT_IDX (SQRT_BITS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   // ---------------------------------------------------------------- result queue
   sgm_rsp_type push_data;

   always_comb begin
      push_data.edge_magnitude = cell_data[SQRT_BITS].root;
      push_data.center_row     = cell_data[SQRT_BITS].meta.center_row;
      push_data.center_col     = cell_data[SQRT_BITS].meta.center_col;
      push_data.frame_last     = cell_data[SQRT_BITS].meta.frame_last;
   end

   sgm_result_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cell_valid[SQRT_BITS]),
      .push_data  (push_data),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

endmodule

[rtl/sgm_checker.sv]
// Port-level checks for the Sobel gradient magnitude unit, bound to the top level.
// Depends on sgm_pkg and sobel_gradient_magnitude_unit.
`timescale 1ns / 1ps

module sgm_checker
   import sgm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input sgm_rsp_type rsp_data
);

   // Edges from an accepted word to its result first showing on an empty rsp channel
   localparam int RSP_LATENCY = 14;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   // Stall input while the line stores are swept after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken during clearing pass");

   // Drop all results on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // A result on an empty channel comes from a word accepted a fixed time earlier
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, RSP_LATENCY))
      else $error("result appeared without matching input word");

endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_sgm_checker (.*);
